// ===== rtl/ssbv_pkg.sv =====
// Shared types, constants and the control store of the stereo post-processor.
package ssbv_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int X_W        = 17;
	localparam int Y_W        = 17;
	localparam int GAIN_W     = 17;
	localparam int B_W        = 18;
	localparam int Q_SHIFT    = 16;
	localparam int MID_SHIFT  = 15;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;
	localparam int SAMPLE_MIN = -32768;
	localparam int SAMPLE_MAX = 32767;

	localparam logic [GAIN_W-1:0]     Q16_ONE   = 17'h10000;
	localparam logic signed [B_W-1:0] ALPHA_NUM = 18'sd3277;
	localparam logic signed [B_W-1:0] DRY_NUM   = 18'sd52429;

	typedef enum logic [1:0] {
		REG_SURROUND = 2'd0,
		REG_BASS     = 2'd1,
		REG_VOLUME   = 2'd2
	} reg_idx_t;

	typedef logic [3:0] step_t;

	localparam step_t STEP_WAIT = 4'd0;
	localparam step_t STEP_SURR = 4'd1;
	localparam step_t STEP_DIFF = 4'd2;
	localparam step_t STEP_MLO  = 4'd3;
	localparam step_t STEP_MHI  = 4'd4;
	localparam step_t STEP_ACC  = 4'd5;
	localparam step_t STEP_UPD  = 4'd6;
	localparam step_t STEP_MIX  = 4'd7;
	localparam step_t STEP_BASS = 4'd8;
	localparam step_t STEP_GAIN = 4'd9;
	localparam step_t STEP_OUT  = 4'd10;

	typedef enum logic [1:0] {A_DLO, A_DHI, A_X, A_Y} asel_t;
	typedef enum logic [1:0] {B_ALPHA, B_DRY, B_GAIN} bsel_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD_HI, ACC_MIX} acc_op_t;
	typedef enum logic [1:0] {J_NONE, J_NO_SURR, J_NO_BASS, J_ALWAYS} jmp_t;

	typedef struct packed {
		logic    wait_in;
		logic    put_out;
		logic    ld_surr;
		logic    ld_diff;
		logic    mul_en;
		asel_t   a_sel;
		bsel_t   b_sel;
		acc_op_t acc_op;
		logic    ld_s;
		logic    ld_y;
		jmp_t    jmp;
		step_t   tgt;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic surround;
		logic bass;
	} cond_t;

	function automatic ctl_t ucode(input step_t step);
		ctl_t w;
		w = '0;
		case (step)
			STEP_WAIT: begin
				w.wait_in = 1'b1;
				w.jmp     = J_NO_SURR;
				w.tgt     = STEP_DIFF;
			end
			STEP_SURR: begin
				w.ld_surr = 1'b1;
			end
			STEP_DIFF: begin
				w.ld_diff = 1'b1;
				w.jmp     = J_NO_BASS;
				w.tgt     = STEP_GAIN;
			end
			STEP_MLO: begin
				w.mul_en = 1'b1;
				w.a_sel  = A_DLO;
				w.b_sel  = B_ALPHA;
			end
			STEP_MHI: begin
				w.mul_en = 1'b1;
				w.a_sel  = A_DHI;
				w.b_sel  = B_ALPHA;
				w.acc_op = ACC_LOAD;
			end
			STEP_ACC: begin
				w.mul_en = 1'b1;
				w.a_sel  = A_X;
				w.b_sel  = B_DRY;
				w.acc_op = ACC_ADD_HI;
			end
			STEP_UPD: begin
				w.ld_s = 1'b1;
			end
			STEP_MIX: begin
				w.acc_op = ACC_MIX;
			end
			STEP_BASS: begin
				w.ld_y = 1'b1;
			end
			STEP_GAIN: begin
				w.mul_en = 1'b1;
				w.a_sel  = A_Y;
				w.b_sel  = B_GAIN;
			end
			STEP_OUT: begin
				w.put_out = 1'b1;
				w.jmp     = J_ALWAYS;
				w.tgt     = STEP_WAIT;
			end
			default: begin
				w.jmp = J_ALWAYS;
				w.tgt = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/ssbv_if.sv =====
// Sample pair channel interfaces, input and result side.
interface ssbv_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [ssbv_pkg::SAMPLE_W-1:0] left_in;
	logic signed [ssbv_pkg::SAMPLE_W-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface ssbv_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [ssbv_pkg::SAMPLE_W-1:0] left_out;
	logic signed [ssbv_pkg::SAMPLE_W-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/stereo_surround_bass_volume.sv =====
// Top level: register port, sequencer, two channel lanes and the result register.
//
//   channel  role    handshake        payload
//   dry      input   valid / ready    left_in, right_in (signed 16)
//   wet      output  valid / ready    left_out, right_out (signed 16)
//   apb      config  psel / penable   surround_enable, bass_enable, volume_gain
//
// One item at a time: each pair runs through the microcode steps, and turning surround
// or bass boost off skips the steps that serve it; each lane owns one multiplier shared
// by the steps, which handles four products per pair with bass boost on.
// Reset sets surround and bass off, unity gain and both filter states to zero.
// A finished pair waits in the result register while the next pair is taken;
// the last step holds only while an earlier result is still untaken.
module stereo_surround_bass_volume #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ssbv_pkg::ADDR_W-1:0]       paddr,
	input  logic [ssbv_pkg::DATA_W-1:0]       pwdata,
	output logic [ssbv_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	ssbv_in_if.sink                           dry,
	ssbv_out_if.source                        wet
);
	import ssbv_pkg::*;

	logic                     surround_q;
	logic                     bass_q;
	logic [GAIN_W-1:0]        volume_q;
	logic [GAIN_W-1:0]        gain_eff;
	reg_idx_t                 reg_idx;
	logic                     wr;

	ctl_t                     ctl;
	cond_t                    cond;
	logic                     go;

	logic signed [X_W-1:0]    lx;
	logic signed [X_W-1:0]    rx;
	logic signed [X_W:0]      pair_sum;
	logic signed [X_W:0]      pair_adj;
	logic signed [X_W-1:0]    mid;
	logic signed [SAMPLE_W-1:0] l_res;
	logic signed [SAMPLE_W-1:0] r_res;

	logic                     wet_valid_q;
	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;
	logic                     out_free;
	logic                     load_out;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr      = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surround_q <= 1'b0;
			bass_q     <= 1'b0;
			volume_q   <= Q16_ONE;
		end else if (wr) begin
			case (reg_idx)
				REG_SURROUND: surround_q <= pwdata[0];
				REG_BASS:     bass_q     <= pwdata[0];
				REG_VOLUME:   volume_q   <= pwdata[GAIN_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SURROUND: prdata = DATA_W'(surround_q);
			REG_BASS:     prdata = DATA_W'(bass_q);
			REG_VOLUME:   prdata = DATA_W'(volume_q);
			default:      prdata = '0;
		endcase
	end

	assign gain_eff = (volume_q > Q16_ONE) ? Q16_ONE : volume_q;

	assign out_free = !wet_valid_q || wet.ready;
	assign load_out = go && ctl.put_out;

	always_comb begin
		cond.in_valid = dry.valid;
		cond.out_free = out_free;
		cond.surround = surround_q;
		cond.bass     = bass_q;
	end

	ssbv_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.ctl    (ctl),
		.go     (go)
	);

	always_comb begin
		pair_sum = lx + rx;
		pair_adj = pair_sum + $signed({1'b0, pair_sum[X_W]});
		mid      = $signed(pair_adj[X_W:1]);
	end

	ssbv_lane #(.FRAC_BITS(FRAC_BITS)) u_left (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.go         (go),
		.sample_in  (dry.left_in),
		.mid        (mid),
		.gain       (gain_eff),
		.x          (lx),
		.sample_out (l_res)
	);

	ssbv_lane #(.FRAC_BITS(FRAC_BITS)) u_right (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.go         (go),
		.sample_in  (dry.right_in),
		.mid        (mid),
		.gain       (gain_eff),
		.x          (rx),
		.sample_out (r_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_valid_q <= 1'b0;
		end else if (load_out) begin
			wet_valid_q <= 1'b1;
		end else if (wet.ready) begin
			wet_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			left_q  <= l_res;
			right_q <= r_res;
		end
	end

	assign dry.ready     = ctl.wait_in;
	assign wet.valid     = wet_valid_q;
	assign wet.left_out  = left_q;
	assign wet.right_out = right_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		dry.valid && dry.ready |=> !dry.ready)
		else $error("second pair taken while one is in progress");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> wet.valid)
		else $error("finished pair not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		wet.valid && !wet.ready |-> !load_out)
		else $error("pending result overwritten");

endmodule

// ===== rtl/ssbv_seq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module ssbv_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  ssbv_pkg::cond_t cond,
	output ssbv_pkg::ctl_t  ctl,
	output logic           go
);
	import ssbv_pkg::*;

	step_t step_q;
	step_t step_d;
	logic  take;

	always_comb begin
		ctl = ucode(step_q);
	end

	always_comb begin
		go = 1'b1;
		if (ctl.wait_in) begin
			go = cond.in_valid;
		end else if (ctl.put_out) begin
			go = cond.out_free;
		end
	end

	always_comb begin
		case (ctl.jmp)
			J_NONE:    take = 1'b0;
			J_NO_SURR: take = !cond.surround;
			J_NO_BASS: take = !cond.bass;
			J_ALWAYS:  take = 1'b1;
			default:   take = 1'b0;
		endcase
	end

	always_comb begin
		step_d = step_q;
		if (go) begin
			step_d = take ? ctl.tgt : step_t'(step_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_OUT)
		else $error("step counter left the program");

	a_bass_skip: assert property (@(posedge clk) disable iff (!arst_n)
		go && ctl.jmp == J_NO_BASS && !cond.bass |=> step_q == STEP_GAIN)
		else $error("bass skip did not reach the gain step");

	a_wait_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wait_in && !cond.in_valid |=> step_q == STEP_WAIT)
		else $error("sequencer left the wait step without a transfer");

endmodule

// ===== rtl/ssbv_lane.sv =====
// One channel datapath: surround, one-pole bass filter, gain and saturation.
module ssbv_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ssbv_pkg::ctl_t                        ctl,
	input  logic                                 go,
	input  logic signed [ssbv_pkg::SAMPLE_W-1:0] sample_in,
	input  logic signed [ssbv_pkg::X_W-1:0]      mid,
	input  logic        [ssbv_pkg::GAIN_W-1:0]   gain,
	output logic signed [ssbv_pkg::X_W-1:0]      x,
	output logic signed [ssbv_pkg::SAMPLE_W-1:0] sample_out
);
	import ssbv_pkg::*;

	localparam int SW   = FRAC_BITS + 17;
	localparam int DW   = FRAC_BITS + 18;
	localparam int HW   = DW - Q_SHIFT;
	localparam int AW   = (HW > X_W) ? HW : X_W;
	localparam int PW   = AW + B_W;
	localparam int ACW  = FRAC_BITS + 35;
	localparam int IW   = ACW - Q_SHIFT;
	localparam int YW   = ACW - FRAC_BITS - Q_SHIFT;
	localparam int FW   = PW - Q_SHIFT;

	logic signed [X_W-1:0] x_q;
	logic signed [SW-1:0]  s_q;
	logic signed [DW-1:0]  d_q;
	logic signed [PW-1:0]  p_q;
	logic signed [ACW-1:0] acc_q;
	logic signed [Y_W-1:0] y_q;

	logic signed [DW-1:0]  x_sh;
	logic signed [DW-1:0]  s_ext;
	logic signed [AW-1:0]  a_op;
	logic signed [B_W-1:0] b_op;
	logic signed [ACW-1:0] p_ext;
	logic signed [ACW-1:0] s_wide;
	logic signed [IW-1:0]  inc;
	logic signed [YW-1:0]  y_bass;
	logic signed [FW-1:0]  y_fin;

	assign x = x_q;

	always_comb begin
		x_sh  = DW'(x_q) <<< FRAC_BITS;
		s_ext = DW'(s_q);
	end

	always_comb begin
		case (ctl.a_sel)
			A_DLO:   a_op = AW'(d_q[Q_SHIFT-1:0]);
			A_DHI:   a_op = AW'($signed(d_q[DW-1:Q_SHIFT]));
			A_X:     a_op = AW'(x_q);
			A_Y:     a_op = AW'(y_q);
			default: a_op = '0;
		endcase
		case (ctl.b_sel)
			B_ALPHA: b_op = ALPHA_NUM;
			B_DRY:   b_op = DRY_NUM;
			B_GAIN:  b_op = B_W'(gain);
			default: b_op = '0;
		endcase
	end

	always_comb begin
		p_ext  = ACW'(p_q);
		s_wide = ACW'(s_q);
		inc    = $signed(acc_q[ACW-1:Q_SHIFT])
			+ $signed({1'b0, acc_q[ACW-1] & (|acc_q[Q_SHIFT-1:0])});
		y_bass = $signed(acc_q[ACW-1:FRAC_BITS+Q_SHIFT])
			+ $signed({1'b0, acc_q[ACW-1] & (|acc_q[FRAC_BITS+Q_SHIFT-1:0])});
		y_fin  = $signed(p_q[PW-1:Q_SHIFT])
			+ $signed({1'b0, p_q[PW-1] & (|p_q[Q_SHIFT-1:0])});
	end

	always_comb begin
		if (y_fin < SAMPLE_MIN) begin
			sample_out = SAMPLE_W'(SAMPLE_MIN);
		end else if (y_fin > SAMPLE_MAX) begin
			sample_out = SAMPLE_W'(SAMPLE_MAX);
		end else begin
			sample_out = y_fin[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (go && ctl.wait_in) begin
			x_q <= {sample_in[SAMPLE_W-1], sample_in};
		end else if (go && ctl.ld_surr) begin
			x_q <= x_q - mid;
		end
		if (go && ctl.ld_diff) begin
			d_q <= x_sh - s_ext;
		end
		if (go && ctl.ld_diff) begin
			y_q <= x_q;
		end else if (go && ctl.ld_y) begin
			y_q <= y_bass[Y_W-1:0];
		end
		if (go && ctl.mul_en) begin
			p_q <= a_op * b_op;
		end
		if (go) begin
			case (ctl.acc_op)
				ACC_HOLD:   acc_q <= acc_q;
				ACC_LOAD:   acc_q <= p_ext;
				ACC_ADD_HI: acc_q <= (p_ext <<< Q_SHIFT) + acc_q;
				ACC_MIX:    acc_q <= (p_ext <<< FRAC_BITS) + (s_wide <<< MID_SHIFT);
				default:    acc_q <= acc_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q <= '0;
		end else if (go && ctl.ld_s) begin
			s_q <= s_q + inc[SW-1:0];
		end
	end

endmodule
